@@ src/sdls_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the switch debounce level selector.
// No dependencies.
package sdls_pkg;

	// Register widths and reset values
	localparam int unsigned REG_W        = 16;
	localparam int unsigned REG_IDX_W    = 3;
	localparam int unsigned LEVEL_W      = 3;
	localparam logic [REG_W-1:0] DEBOUNCE_RST   = 16'd50;
	localparam logic [REG_W-1:0] LONG_PRESS_RST = 16'd3000;

	// Highest selectable level; levels wrap back to LEVEL_FIRST
	localparam logic [LEVEL_W-1:0] LEVEL_OFF   = 3'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_FIRST = 3'd1;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 3'd5;

	// Configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LONG_PRESS = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DUTY_OFF   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DUTY_1     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_DUTY_2     = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_DUTY_3     = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_DUTY_4     = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_DUTY_5     = 3'd7;

	// Stream widths: input word holds pin_level, output word holds the result
	localparam int unsigned S_TDATA_W = 8;
	localparam int unsigned M_TDATA_W = 24;

	// Result word, pressed in the lowest bit
	typedef struct packed {
		logic [REG_W-1:0]   duty;
		logic [LEVEL_W-1:0] level;
		logic               pressed;
	} result_t;

endpackage

@@ src/switch_debounce_level_selector.sv @@
`timescale 1ns / 1ps
// Switch debounce with a press-cycled level selector and duty lookup.
// Depends on sdls_pkg.

// One raw pin sample is taken per word, and every accepted word gives one
// result word: debounced status, selected level (0 off, 1..5) and that level's
// duty register. A word can be accepted every clock cycle while the skid
// register is empty; the debounce, level and hold-timer update is done in the
// cycle of acceptance and the result is registered in a two-entry output
// buffer (output register plus skid register) that keeps the input side open
// for one more word while a result waits to be taken. The user writes
// configuration through cfg_we/cfg_addr/cfg_data while the block is idle; the block does not enforce it.
module switch_debounce_level_selector (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [sdls_pkg::REG_IDX_W-1:0]  cfg_addr,
	input  logic [sdls_pkg::REG_W-1:0]      cfg_data,
	// input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [sdls_pkg::S_TDATA_W-1:0]  s_tdata,   // [0] pin_level, rest zero
	// output stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [sdls_pkg::M_TDATA_W-1:0]  m_tdata    // [0] pressed, [3:1] level,
	                                                   // [19:4] duty, rest zero
);
	import sdls_pkg::*;

	// configuration registers
	logic [REG_W-1:0] debounce_q, long_press_q;
	logic [REG_W-1:0] duty_off_q, duty1_q, duty2_q, duty3_q, duty4_q, duty5_q;

	// block state
	logic [REG_W-1:0]   high_ticks_q, low_ticks_q, hold_ticks_q;
	logic               status_q;
	logic [LEVEL_W-1:0] level_q;

	// output buffer
	result_t out_q, skid_q;
	logic    out_valid_q, skid_valid_q;

	// next-state logic
	logic               in_fire;
	logic               pin;
	logic [REG_W:0]     high_inc, low_inc, hold_inc;
	logic [REG_W-1:0]   high_nx, low_nx, hold_nx;
	logic               status_nx;
	logic [LEVEL_W-1:0] level_adv, level_nx;
	result_t            res;

	assign s_tready = !skid_valid_q;
	assign in_fire  = s_tvalid && s_tready;
	assign pin      = s_tdata[0];
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(M_TDATA_W - $bits(result_t)){1'b0}}, out_q};

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RST;
			long_press_q <= LONG_PRESS_RST;
			duty_off_q   <= '0;
			duty1_q      <= '0;
			duty2_q      <= '0;
			duty3_q      <= '0;
			duty4_q      <= '0;
			duty5_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_DEBOUNCE:   debounce_q   <= cfg_data;
				REG_LONG_PRESS: long_press_q <= cfg_data;
				REG_DUTY_OFF:   duty_off_q   <= cfg_data;
				REG_DUTY_1:     duty1_q      <= cfg_data;
				REG_DUTY_2:     duty2_q      <= cfg_data;
				REG_DUTY_3:     duty3_q      <= cfg_data;
				REG_DUTY_4:     duty4_q      <= cfg_data;
				REG_DUTY_5:     duty5_q      <= cfg_data;
				default:        ;
			endcase
		end
	end

	// debounce counters, level stepping and hold timer
	always_comb begin
		high_nx   = high_ticks_q;
		low_nx    = low_ticks_q;
		status_nx = status_q;
		high_inc  = {1'b0, high_ticks_q} + 1'b1;
		low_inc   = {1'b0, low_ticks_q} + 1'b1;
		if (pin) begin
			if (high_inc >= {1'b0, debounce_q}) begin
				high_nx   = '0;
				status_nx = 1'b1;
			end else begin
				high_nx = high_inc[REG_W-1:0];
			end
		end else begin
			if (low_inc >= {1'b0, debounce_q}) begin
				low_nx    = '0;
				status_nx = 1'b0;
			end else begin
				low_nx = low_inc[REG_W-1:0];
			end
		end

		// falling edge of the status steps the level, wrapping after the top
		level_adv = (level_q >= LEVEL_MAX) ? LEVEL_FIRST : level_q + 1'b1;
		level_nx  = (status_q && !status_nx) ? level_adv : level_q;

		// long press saturates the timer and turns the level off
		hold_inc = {1'b0, hold_ticks_q} + 1'b1;
		hold_nx  = '0;
		if (status_nx) begin
			if (hold_inc >= {1'b0, long_press_q}) begin
				hold_nx  = long_press_q;
				level_nx = LEVEL_OFF;
			end else begin
				hold_nx = hold_inc[REG_W-1:0];
			end
		end

		// duty lookup
		res.pressed = status_nx;
		res.level   = level_nx;
		unique case (level_nx)
			3'd1:    res.duty = duty1_q;
			3'd2:    res.duty = duty2_q;
			3'd3:    res.duty = duty3_q;
			3'd4:    res.duty = duty4_q;
			3'd5:    res.duty = duty5_q;
			default: res.duty = duty_off_q;
		endcase
	end

	// state update on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_ticks_q <= '0;
			low_ticks_q  <= '0;
			hold_ticks_q <= '0;
			status_q     <= 1'b0;
			level_q      <= LEVEL_OFF;
		end else if (in_fire) begin
			high_ticks_q <= high_nx;
			low_ticks_q  <= low_nx;
			hold_ticks_q <= hold_nx;
			status_q     <= status_nx;
			level_q      <= level_nx;
		end
	end

	// output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_fire;
			end
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_fire) begin
				out_q <= res;
			end
		end else if (in_fire) begin
			skid_q <= res;
		end
	end

endmodule

@@ bench/tb_switch_debounce_level_selector.sv @@
`timescale 1ns / 1ps
// Testbench for switch_debounce_level_selector: directed and random pin words,
// a per-word predictor inside a scoreboard class, random stalls on both streams.
// Depends on sdls_pkg and the block under test.
module tb_switch_debounce_level_selector;
	import sdls_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int LONG_HOLD      = 80;
	localparam int DRAIN_CYCLES   = 3;

	// duty fill modes for a phase
	localparam int DUTY_RANDOM = 0;
	localparam int DUTY_ONES   = 1;
	localparam int DUTY_ZEROS  = 2;

	// presses that walk the level through a full wrap, then a long press and a release
	localparam bit [0:17] PRESS_SEQ  = 18'b101010101010111110;
	// status follows the pin at once with a zero debounce count
	localparam bit [0:4]  FOLLOW_SEQ = 5'b10110;

	// random phases: debounce count, long-press limit, words, duty fill
	localparam int PH_DB[8]    = '{1, 3, 2, 0, 20, 2, 65535, 5};
	localparam int PH_LP[8]    = '{4, 12, 65535, 0, 40, 1, 65535, 30};
	localparam int PH_WORDS[8] = '{110, 180, 110, 70, 140, 90, 50, 130};
	localparam int PH_DUTY[8]  = '{DUTY_RANDOM, DUTY_RANDOM, DUTY_RANDOM, DUTY_ONES,
		DUTY_RANDOM, DUTY_RANDOM, DUTY_ZEROS, DUTY_RANDOM};
	localparam int PRESSURE_PHASE = 1;

	// Predicts the debounced status, level and duty of every accepted pin word
	class selector_scoreboard;
		logic [REG_W-1:0]   debounce_lim;
		logic [REG_W-1:0]   long_press_lim;
		logic [REG_W-1:0]   duty_tbl[6];
		logic [REG_W-1:0]   high_cnt;
		logic [REG_W-1:0]   low_cnt;
		logic [REG_W-1:0]   hold_cnt;
		logic               status;
		logic               status_prev;
		logic [LEVEL_W-1:0] step;
		result_t            expected_results[$];
		int                 errors;

		function new();
			debounce_lim   = DEBOUNCE_RST;
			long_press_lim = LONG_PRESS_RST;
			foreach (duty_tbl[k])
				duty_tbl[k] = '0;
			high_cnt    = '0;
			low_cnt     = '0;
			hold_cnt    = '0;
			status      = 1'b0;
			status_prev = 1'b0;
			step        = LEVEL_OFF;
			errors      = 0;
		endfunction

		function void set_reg(logic [REG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
			case (idx)
				REG_DEBOUNCE: begin
					debounce_lim = val;
				end
				REG_LONG_PRESS: begin
					long_press_lim = val;
				end
				default: begin
					duty_tbl[int'(idx) - int'(REG_DUTY_OFF)] = val;
				end
			endcase
		endfunction

		function void note_pin(bit pin);
			logic [REG_W:0] nxt;
			result_t        r;
			// counters compare as incremented values, one extra bit so nothing wraps
			if (pin) begin
				nxt = {1'b0, high_cnt} + 1'b1;
				if (nxt >= {1'b0, debounce_lim}) begin
					high_cnt = '0;
					status   = 1'b1;
				end else begin
					high_cnt = nxt[REG_W-1:0];
				end
			end else begin
				nxt = {1'b0, low_cnt} + 1'b1;
				if (nxt >= {1'b0, debounce_lim}) begin
					low_cnt = '0;
					status  = 1'b0;
				end else begin
					low_cnt = nxt[REG_W-1:0];
				end
			end
			// falling edge of status steps the level, wrapping back to the first
			if (!status && status_prev) begin
				step = step + 1'b1;
				if (step > LEVEL_MAX)
					step = LEVEL_FIRST;
			end
			status_prev = status;
			// hold timer saturates at the long-press limit and forces level off
			if (status) begin
				nxt = {1'b0, hold_cnt} + 1'b1;
				if (nxt >= {1'b0, long_press_lim}) begin
					hold_cnt = long_press_lim;
					step     = LEVEL_OFF;
				end else begin
					hold_cnt = nxt[REG_W-1:0];
				end
			end else begin
				hold_cnt = '0;
			end
			r.pressed = status;
			r.level   = step;
			r.duty    = (step <= LEVEL_MAX) ? duty_tbl[step] : duty_tbl[0];
			expected_results.push_back(r);
		endfunction

		function void check_result(logic [M_TDATA_W-1:0] word);
			result_t got;
			result_t want;
			got = word[$bits(result_t)-1:0];
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: result word %h with nothing expected", $time, word);
				return;
			end
			want = expected_results.pop_front();
			if (got.pressed !== want.pressed) begin
				errors++;
				$display("%0t: pressed expected %b actual %b", $time, want.pressed, got.pressed);
			end
			if (got.level !== want.level) begin
				errors++;
				$display("%0t: level expected %0d actual %0d", $time, want.level, got.level);
			end
			if (got.duty !== want.duty) begin
				errors++;
				$display("%0t: duty expected %h actual %h", $time, want.duty, got.duty);
			end
			// padding above the result must stay zero
			if (word[M_TDATA_W-1:$bits(result_t)] !== '0) begin
				errors++;
				$display("%0t: padding expected 0 actual %h", $time,
					word[M_TDATA_W-1:$bits(result_t)]);
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 cfg_we   = 1'b0;
	logic [REG_IDX_W-1:0] cfg_addr = '0;
	logic [REG_W-1:0]     cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;  // [0] pin_level, rest zero
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;        // [0] pressed, [3:1] level, [19:4] duty

	selector_scoreboard sb = new();

	bit gaps_on   = 1'b1;
	bit stalls_on = 1'b1;
	int hold_reqs = 0;
	int hold_seen = 0;
	int stall_left = 0;
	int idle_cycles = 0;

	switch_debounce_level_selector DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #6 clk = ~clk;

	// Receiver: random stall bursts, plus one long hold-off when requested
	always @(posedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen  = hold_reqs;
			stall_left = LONG_HOLD;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (stalls_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 11) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Result check and watchdog on words moved
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("FAIL switch_debounce_level_selector");
					$finish;
				end
			end
		end
	end

	// One pin word, with an optional gap in front
	task automatic send_pin(bit pin);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_TDATA_W-1){1'b0}}, pin};
		do @(posedge clk); while (!s_tready);
		sb.note_pin(pin);
	endtask

	// Stop offering and wait for every expected result, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic load_regs(int db, int lp, int duty_mode);
		logic [REG_W-1:0] val;
		write_reg(REG_DEBOUNCE, REG_W'(db));
		write_reg(REG_LONG_PRESS, REG_W'(lp));
		for (int k = 0; k < 6; k++) begin
			case (duty_mode)
				DUTY_ONES:  val = '1;
				DUTY_ZEROS: val = '0;
				default:    val = REG_W'($urandom);
			endcase
			write_reg(REG_DUTY_OFF + REG_IDX_W'(k), val);
		end
		cfg_we <= 1'b0;
	endtask

	// Runs of one level sized around the debounce count, some long presses,
	// and bursts of bounce noise
	task automatic random_runs(int n_words, int db, int lp);
		int sent;
		int len;
		bit lvl;
		sent = 0;
		lvl  = 1'($urandom_range(0, 1));
		while (sent < n_words) begin
			if ($urandom_range(0, 4) == 0) begin
				len = $urandom_range(1, 6);
				for (int k = 0; k < len; k++)
					send_pin(1'($urandom_range(0, 1)));
			end else begin
				if (lvl && $urandom_range(0, 3) == 0)
					len = $urandom_range(1, (lp + 4 > 200) ? 200 : lp + 4);
				else
					len = $urandom_range(1, (2 * db + 3 > 120) ? 120 : 2 * db + 3);
				for (int k = 0; k < len; k++)
					send_pin(lvl);
				lvl = !lvl;
			end
			sent += len;
		end
	endtask

	// Stimulus sequence
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values of the registers
		random_runs(100, DEBOUNCE_RST, LONG_PRESS_RST);
		drain();

		// full level wrap, long press, release
		load_regs(1, 4, DUTY_RANDOM);
		for (int k = 0; k < 18; k++)
			send_pin(PRESS_SEQ[k]);
		drain();

		// zero debounce count and zero long-press limit
		load_regs(0, 0, DUTY_ONES);
		for (int k = 0; k < 5; k++)
			send_pin(FOLLOW_SEQ[k]);
		drain();

		for (int p = 0; p < 8; p++) begin
			if (p == 7) begin
				gaps_on   = 1'b0;
				stalls_on = 1'b0;
			end
			load_regs(PH_DB[p], PH_LP[p], PH_DUTY[p]);
			if (p == PRESSURE_PHASE) begin
				random_runs(PH_WORDS[p] / 3, PH_DB[p], PH_LP[p]);
				hold_reqs++;
				random_runs(PH_WORDS[p] / 3, PH_DB[p], PH_LP[p]);
				drain();
				random_runs(PH_WORDS[p] / 3, PH_DB[p], PH_LP[p]);
			end else begin
				random_runs(PH_WORDS[p], PH_DB[p], PH_LP[p]);
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS switch_debounce_level_selector");
		else
			$display("FAIL switch_debounce_level_selector");
		$finish;
	end

endmodule
